FILE: src/lcs_pkg.sv
// Shared types, constants and pattern tables for the LED chaser with speed keys.
// No dependencies; every other file but lcs_if uses these through scoped names.
package lcs_pkg;

   // Dwell and countdown counter width
   localparam int COUNT_WIDTH = 17;
   localparam int STEP_W      = 16;
   localparam int LIMIT_W     = 17;
   localparam int CSR_DATA_W  = 17;
   localparam int CSR_IDX_W   = 2;
   localparam int IDX_W       = 4;
   // Common width for dwell arithmetic: room for a sum without wrap
   localparam int WIDE_W      = ((COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W) + 1;

   localparam longint unsigned COUNT_MAX_L = (64'd1 << COUNT_WIDTH) - 64'd1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = COUNT_WIDTH'(COUNT_MAX_L);
   localparam longint unsigned DWELL_RESET = 64'd10000;
   localparam logic [COUNT_WIDTH-1:0] DWELL_RESET_LIM =
      COUNT_WIDTH'((DWELL_RESET > COUNT_MAX_L) ? COUNT_MAX_L : DWELL_RESET);

   // Mode codes
   localparam logic [1:0] MODE_TICK     = 2'd0;
   localparam logic [1:0] MODE_SWEEP    = 2'd1;
   localparam logic [1:0] MODE_CONVERGE = 2'd2;

   // Key codes
   localparam logic [7:0] KEY_FASTER = 8'd119;
   localparam logic [7:0] KEY_SLOWER = 8'd115;
   localparam logic [7:0] KEY_STOP   = 8'd27;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_STEP    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_FLOOR   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_CEILING = 2'd2;

   // Register reset values
   localparam logic [STEP_W-1:0]  DELAY_STEP_RST    = 16'd1000;
   localparam logic [LIMIT_W-1:0] DELAY_FLOOR_RST   = 17'd1000;
   localparam logic [LIMIT_W-1:0] DELAY_CEILING_RST = 17'd100000;

   // Pattern lengths
   localparam logic [IDX_W-1:0] SWEEP_LEN    = 4'd14;
   localparam logic [IDX_W-1:0] CONVERGE_LEN = 4'd7;

   typedef struct packed {
      logic [1:0] mode;
      logic       key_valid;
      logic [7:0] key_code;
   } req_type;

   typedef struct packed {
      logic [7:0] leds;
      logic       running;
      logic       pattern_id;
   } rsp_type;

   typedef struct packed {
      logic [STEP_W-1:0]  delay_step;
      logic [LIMIT_W-1:0] delay_floor;
      logic [LIMIT_W-1:0] delay_ceiling;
   } csr_type;

   // LED value of one step; pattern 0 is the sweep, 1 the converge
   function automatic logic [7:0] pattern_value(input logic pat, input logic [IDX_W-1:0] idx);
      logic [7:0] val;
      val = 8'h00;
      if (pat) begin
         case (idx)
            4'd0:    val = 8'h81;
            4'd1:    val = 8'h42;
            4'd2:    val = 8'h24;
            4'd3:    val = 8'h18;
            4'd4:    val = 8'h18;
            4'd5:    val = 8'h24;
            4'd6:    val = 8'h42;
            default: val = 8'h00;
         endcase
      end else begin
         case (idx)
            4'd0:    val = 8'h80;
            4'd1:    val = 8'h40;
            4'd2:    val = 8'h20;
            4'd3:    val = 8'h10;
            4'd4:    val = 8'h08;
            4'd5:    val = 8'h04;
            4'd6:    val = 8'h02;
            4'd7:    val = 8'h01;
            4'd8:    val = 8'h02;
            4'd9:    val = 8'h04;
            4'd10:   val = 8'h08;
            4'd11:   val = 8'h10;
            4'd12:   val = 8'h20;
            4'd13:   val = 8'h40;
            default: val = 8'h00;
         endcase
      end
      return val;
   endfunction

   // Step index after an advance, wrapping at the pattern length
   function automatic logic [IDX_W-1:0] next_index(input logic pat, input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] len;
      logic [IDX_W-1:0] inc;
      len = pat ? CONVERGE_LEN : SWEEP_LEN;
      inc = idx + IDX_W'(1);
      return (inc >= len) ? '0 : inc;
   endfunction

endpackage

FILE: src/lcs_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on nothing; payload fields match the chaser's item fields.
interface lcs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic       key_valid;
   logic [7:0] key_code;

   modport source (output valid, output mode, output key_valid, output key_code, input ready);
   modport sink   (input valid, input mode, input key_valid, input key_code, output ready);
endinterface

interface lcs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] leds;
   logic       running;
   logic       pattern_id;

   modport source (output valid, output leds, output running, output pattern_id, input ready);
   modport sink   (input valid, input leds, input running, input pattern_id, output ready);
endinterface

FILE: src/lcs_dwell_adj.sv
// Speed key decode and dwell adjust: lowers, raises or keeps the active dwell.
// Depends on lcs_pkg.
module lcs_dwell_adj (
   input  logic [lcs_pkg::COUNT_WIDTH-1:0] dwell,
   input  logic                            key_valid,
   input  logic [7:0]                      key_code,
   input  lcs_pkg::csr_type                csr,
   output logic [lcs_pkg::COUNT_WIDTH-1:0] dwell_out,
   output logic                            stop
);

   logic [lcs_pkg::WIDE_W-1:0] dw_w;
   logic [lcs_pkg::WIDE_W-1:0] step_w;
   logic [lcs_pkg::WIDE_W-1:0] floor_w;
   logic [lcs_pkg::WIDE_W-1:0] ceil_raw;
   logic [lcs_pkg::WIDE_W-1:0] ceil_w;
   logic [lcs_pkg::WIDE_W-1:0] sum_w;
   logic [lcs_pkg::WIDE_W-1:0] diff_w;

   // Operands in one common width
   assign dw_w     = lcs_pkg::WIDE_W'(dwell);
   assign step_w   = lcs_pkg::WIDE_W'(csr.delay_step);
   assign floor_w  = lcs_pkg::WIDE_W'(csr.delay_floor);
   assign ceil_raw = lcs_pkg::WIDE_W'(csr.delay_ceiling);
   // Ceiling never above what the counter holds
   assign ceil_w   = (ceil_raw > lcs_pkg::WIDE_W'(lcs_pkg::COUNT_MAX)) ?
                     lcs_pkg::WIDE_W'(lcs_pkg::COUNT_MAX) : ceil_raw;
   assign sum_w    = dw_w + step_w;
   assign diff_w   = (dw_w >= step_w) ? (dw_w - step_w) : '0;

   // Key decode
   always_comb begin
      dwell_out = dwell;
      stop      = 1'b0;
      if (key_valid) begin
         case (key_code)
            lcs_pkg::KEY_FASTER: begin
               if (dw_w > floor_w) begin
                  dwell_out = diff_w[lcs_pkg::COUNT_WIDTH-1:0];
               end
            end
            lcs_pkg::KEY_SLOWER: begin
               dwell_out = (sum_w > ceil_w) ? ceil_w[lcs_pkg::COUNT_WIDTH-1:0] :
                                              sum_w[lcs_pkg::COUNT_WIDTH-1:0];
            end
            lcs_pkg::KEY_STOP: begin
               stop = 1'b1;
            end
            default: begin
               dwell_out = dwell;
            end
         endcase
      end
   end

endmodule

FILE: src/lcs_seq.sv
// Sequencer state: run flag, pattern, step, countdown, per-pattern dwell, LEDs.
// Depends on lcs_pkg and lcs_dwell_adj; updates once per accepted beat.
module lcs_seq (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  lcs_pkg::req_type item,
   input  lcs_pkg::csr_type csr,
   output lcs_pkg::rsp_type rsp_next
);

   logic                            active_ff, active_in;
   logic                            which_ff, which_in;
   logic [lcs_pkg::IDX_W-1:0]       idx_ff, idx_in;
   logic [lcs_pkg::COUNT_WIDTH-1:0] countdown_ff, countdown_in;
   logic [lcs_pkg::COUNT_WIDTH-1:0] dwell_ff [2];
   logic [lcs_pkg::COUNT_WIDTH-1:0] dwell_in [2];
   logic [7:0]                      leds_ff, leds_in;

   logic                            start;
   logic                            tick;
   logic                            start_pat;
   logic [lcs_pkg::COUNT_WIDTH-1:0] adj_dwell;
   logic                            adj_stop;

   assign start     = (item.mode == lcs_pkg::MODE_SWEEP) || (item.mode == lcs_pkg::MODE_CONVERGE);
   assign tick      = (item.mode == lcs_pkg::MODE_TICK) && active_ff;
   assign start_pat = (item.mode == lcs_pkg::MODE_CONVERGE);

   lcs_dwell_adj u_dwell_adj (
      .dwell     (dwell_ff[which_ff]),
      .key_valid (item.key_valid),
      .key_code  (item.key_code),
      .csr       (csr),
      .dwell_out (adj_dwell),
      .stop      (adj_stop)
   );

   // Next state for the beat in the input register
   always_comb begin
      active_in    = active_ff;
      which_in     = which_ff;
      idx_in       = idx_ff;
      countdown_in = countdown_ff;
      dwell_in[0]  = dwell_ff[0];
      dwell_in[1]  = dwell_ff[1];
      leds_in      = leds_ff;
      if (fire) begin
         if (start) begin
            which_in     = start_pat;
            idx_in       = '0;
            active_in    = 1'b1;
            leds_in      = lcs_pkg::pattern_value(start_pat, '0);
            countdown_in = dwell_ff[start_pat];
         end else if (tick) begin
            dwell_in[which_ff] = adj_dwell;
            if (adj_stop) begin
               active_in = 1'b0;
               leds_in   = 8'h00;
            end else if (countdown_ff <= lcs_pkg::COUNT_WIDTH'(1)) begin
               idx_in       = lcs_pkg::next_index(which_ff, idx_ff);
               leds_in      = lcs_pkg::pattern_value(which_ff, idx_in);
               countdown_in = adj_dwell;
            end else begin
               countdown_in = countdown_ff - lcs_pkg::COUNT_WIDTH'(1);
            end
         end
      end
   end

   assign rsp_next = '{leds: leds_in, running: active_in, pattern_id: which_in};

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         which_ff     <= 1'b0;
         idx_ff       <= '0;
         countdown_ff <= '0;
         dwell_ff[0]  <= lcs_pkg::DWELL_RESET_LIM;
         dwell_ff[1]  <= lcs_pkg::DWELL_RESET_LIM;
         leds_ff      <= 8'h00;
      end else begin
         active_ff    <= active_in;
         which_ff     <= which_in;
         idx_ff       <= idx_in;
         countdown_ff <= countdown_in;
         dwell_ff[0]  <= dwell_in[0];
         dwell_ff[1]  <= dwell_in[1];
         leds_ff      <= leds_in;
      end
   end

   // LEDs are dark whenever the sequence is stopped
   a_dark_when_idle: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (leds_ff == 8'h00))
      else $error("LEDs lit while sequence stopped");

   // Step index stays inside the selected pattern
   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      (which_ff ? (idx_ff < lcs_pkg::CONVERGE_LEN) : (idx_ff < lcs_pkg::SWEEP_LEN)))
      else $error("step index outside pattern");

   // A start beat leaves the sequence running at its first step
   a_start_effect: assert property (@(posedge clock) disable iff (reset)
      (fire && start) |=> (active_ff && (idx_ff == '0) && (which_ff == $past(start_pat))))
      else $error("start beat did not restart the sequence");

endmodule

FILE: src/led_chaser_with_speed_keys.sv
// Top level of the LED chaser: input register, sequencer, result register, CSRs.
// Depends on lcs_pkg, lcs_if, lcs_seq (which uses lcs_dwell_adj).

// One request beat is taken every clock cycle while the input register is
// free or moving on; each beat yields exactly one response beat, the LED
// pattern, run flag and pattern id as they stand after that beat. A beat
// lands in the input register, the sequencer updates its state in one pass
// and the result enters the output register once that is free or read.
// The two registers let a request in while a finished response awaits ready.
// Mode 1 or 2 starts the sweep or the converge pattern; mode 0 is a tick that
// counts down the dwell, with keys w and s changing the dwell of the running
// pattern and escape stopping it. Write the delay registers only while idle.
module led_chaser_with_speed_keys (
   input  logic                             clock,
   input  logic                             reset,
   lcs_req_if.sink                          req_bus,
   lcs_rsp_if.source                        rsp_bus,
   input  logic                             csr_write_en,
   input  logic [lcs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lcs_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic             in_valid_ff, in_valid_in;
   lcs_pkg::req_type in_item_ff;
   logic             out_valid_ff, out_valid_in;
   lcs_pkg::rsp_type out_item_ff;
   lcs_pkg::csr_type csr_ff, csr_in;
   lcs_pkg::rsp_type rsp_next;
   logic             advance;
   logic             req_fire;

   // Pipeline flow: input register moves on when the result slot frees up
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_fire     = req_bus.valid && req_bus.ready;
   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : ((rsp_bus.ready) ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= '{mode: req_bus.mode, key_valid: req_bus.key_valid,
                         key_code: req_bus.key_code};
      end
      if (advance) begin
         out_item_ff <= rsp_next;
      end
   end

   // Configuration registers
   always_comb begin
      csr_in = csr_ff;
      if (csr_write_en) begin
         case (csr_index)
            lcs_pkg::CSR_DELAY_STEP:    csr_in.delay_step    = csr_wdata[lcs_pkg::STEP_W-1:0];
            lcs_pkg::CSR_DELAY_FLOOR:   csr_in.delay_floor   = csr_wdata[lcs_pkg::LIMIT_W-1:0];
            lcs_pkg::CSR_DELAY_CEILING: csr_in.delay_ceiling = csr_wdata[lcs_pkg::LIMIT_W-1:0];
            default:                    csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '{delay_step: lcs_pkg::DELAY_STEP_RST,
                     delay_floor: lcs_pkg::DELAY_FLOOR_RST,
                     delay_ceiling: lcs_pkg::DELAY_CEILING_RST};
      end else begin
         csr_ff <= csr_in;
      end
   end

   lcs_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .item     (in_item_ff),
      .csr      (csr_ff),
      .rsp_next (rsp_next)
   );

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.leds       = out_item_ff.leds;
   assign rsp_bus.running    = out_item_ff.running;
   assign rsp_bus.pattern_id = out_item_ff.pattern_id;

endmodule

FILE: bench/tb_led_chaser_with_speed_keys.sv
// Self-checking bench for the LED chaser with speed keys: directed and random ticks,
// starts and key presses, checked beat by beat against an in-bench display predictor.
// Depends on lcs_pkg, lcs_if and the led_chaser_with_speed_keys top level.
module tb_led_chaser_with_speed_keys;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD = 10;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 6;
   localparam int LONG_HOLD = 200;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_BEATS = 205;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [lcs_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [7:0] KEY_OTHER = 8'hFF;
   localparam logic [lcs_pkg::LIMIT_W-1:0] LIMIT_MAX = '1;
   localparam logic [lcs_pkg::STEP_W-1:0] STEP_MAX = '1;

   // LED sequences, first step at index 0
   localparam logic [0:13][7:0] SWEEP_SEQ = {8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04,
      8'h02, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40};
   localparam logic [0:6][7:0] CONVERGE_SEQ = {8'h81, 8'h42, 8'h24, 8'h18, 8'h18, 8'h24,
      8'h42};

   // Tracks the chaser state and holds the displays still owed by the block
   class display_predictor;
      logic [lcs_pkg::STEP_W-1:0] step_size;
      logic [lcs_pkg::LIMIT_W-1:0] dwell_floor;
      logic [lcs_pkg::LIMIT_W-1:0] dwell_ceiling;
      bit running;
      bit converge;
      int unsigned step_pos;
      logic [lcs_pkg::COUNT_WIDTH-1:0] countdown;
      logic [lcs_pkg::COUNT_WIDTH-1:0] dwell[2];
      logic [7:0] leds;
      lcs_pkg::rsp_type expected_displays[$];
      int unsigned mismatches;

      function new();
         step_size = lcs_pkg::DELAY_STEP_RST;
         dwell_floor = lcs_pkg::DELAY_FLOOR_RST;
         dwell_ceiling = lcs_pkg::DELAY_CEILING_RST;
         running = 0;
         converge = 0;
         step_pos = 0;
         countdown = '0;
         dwell[0] = lcs_pkg::DWELL_RESET_LIM;
         dwell[1] = lcs_pkg::DWELL_RESET_LIM;
         leds = 8'h00;
         mismatches = 0;
      endfunction

      function void set_register(input logic [lcs_pkg::CSR_IDX_W-1:0] index,
                                 input logic [lcs_pkg::CSR_DATA_W-1:0] data);
         case (index)
            lcs_pkg::CSR_DELAY_STEP: step_size = data[lcs_pkg::STEP_W-1:0];
            lcs_pkg::CSR_DELAY_FLOOR: dwell_floor = data[lcs_pkg::LIMIT_W-1:0];
            lcs_pkg::CSR_DELAY_CEILING: dwell_ceiling = data[lcs_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [7:0] step_leds(input bit conv, input int unsigned pos);
         if (conv) return CONVERGE_SEQ[pos];
         return SWEEP_SEQ[pos];
      endfunction

      // Apply one request beat and queue the display it leaves behind
      function void note_beat(input lcs_pkg::req_type b);
         lcs_pkg::rsp_type want;
         logic [lcs_pkg::WIDE_W-1:0] raised;
         logic [lcs_pkg::WIDE_W-1:0] cap;
         int unsigned len;
         bit halt;
         halt = 0;
         if (b.mode == lcs_pkg::MODE_SWEEP || b.mode == lcs_pkg::MODE_CONVERGE) begin
            converge = (b.mode == lcs_pkg::MODE_CONVERGE);
            step_pos = 0;
            running = 1;
            leds = step_leds(converge, 0);
            countdown = dwell[converge];
         end else if (b.mode == lcs_pkg::MODE_TICK && running) begin
            if (b.key_valid) begin
               if (b.key_code == lcs_pkg::KEY_FASTER) begin
                  if (dwell[converge] > dwell_floor)
                     dwell[converge] = (dwell[converge] >= step_size) ?
                                       dwell[converge] - step_size : '0;
               end else if (b.key_code == lcs_pkg::KEY_SLOWER) begin
                  // saturate at the ceiling, itself capped at the counter maximum
                  cap = (dwell_ceiling > lcs_pkg::COUNT_MAX) ?
                        lcs_pkg::WIDE_W'(lcs_pkg::COUNT_MAX) :
                        lcs_pkg::WIDE_W'(dwell_ceiling);
                  raised = lcs_pkg::WIDE_W'(dwell[converge]) + lcs_pkg::WIDE_W'(step_size);
                  if (raised > cap) raised = cap;
                  dwell[converge] = raised[lcs_pkg::COUNT_WIDTH-1:0];
               end else if (b.key_code == lcs_pkg::KEY_STOP) begin
                  halt = 1;
               end
            end
            if (halt) begin
               running = 0;
               leds = 8'h00;
            end else if (countdown <= 1) begin
               len = converge ? 32'(lcs_pkg::CONVERGE_LEN) : 32'(lcs_pkg::SWEEP_LEN);
               step_pos = (step_pos + 1 >= len) ? 0 : step_pos + 1;
               leds = step_leds(converge, step_pos);
               countdown = dwell[converge];
            end else begin
               countdown = countdown - lcs_pkg::COUNT_WIDTH'(1);
            end
         end
         want.leds = leds;
         want.running = running;
         want.pattern_id = converge;
         expected_displays.push_back(want);
      endfunction

      // Compare a response beat with the oldest owed display
      function void check_beat(input lcs_pkg::rsp_type got);
         lcs_pkg::rsp_type want;
         if (expected_displays.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual leds %h running %b id %b",
                     $time, got.leds, got.running, got.pattern_id);
            mismatches++;
            return;
         end
         want = expected_displays.pop_front();
         if (got.leds !== want.leds) begin
            $display("%0t: leds expected %h actual %h", $time, want.leds, got.leds);
            mismatches++;
         end
         if (got.running !== want.running) begin
            $display("%0t: running expected %b actual %b", $time, want.running, got.running);
            mismatches++;
         end
         if (got.pattern_id !== want.pattern_id) begin
            $display("%0t: pattern_id expected %b actual %b", $time, want.pattern_id,
                     got.pattern_id);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_write_en;
   logic [lcs_pkg::CSR_IDX_W-1:0] csr_index;
   logic [lcs_pkg::CSR_DATA_W-1:0] csr_wdata;
   int unsigned cycles = 0;
   bit steady = 0;
   bit hold_pending = 0;
   display_predictor predictor = new();

   lcs_req_if req_bus();
   lcs_rsp_if rsp_bus();

   led_chaser_with_speed_keys i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Response side: check each beat, stall in bursts and once for a long stretch
   initial begin
      int unsigned hold_left;
      lcs_pkg::rsp_type got;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.leds = rsp_bus.leds;
            got.running = rsp_bus.running;
            got.pattern_id = rsp_bus.pattern_id;
            predictor.check_beat(got);
         end
         if (hold_left > 0) begin
            hold_left--;
         end else if (hold_pending) begin
            hold_pending = 0;
            hold_left = LONG_HOLD;
         end else if (!steady && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(1, 16);
         end
         rsp_bus.ready <= (hold_left == 0) && !reset;
      end
   end

   function automatic lcs_pkg::req_type beat(input logic [1:0] mode, input logic kv,
                                             input logic [7:0] code);
      lcs_pkg::req_type b;
      b.mode = mode;
      b.key_valid = kv;
      b.key_code = code;
      return b;
   endfunction

   // Mostly ticks with speed keys, some starts, rare escapes and unused modes
   function automatic lcs_pkg::req_type random_beat();
      lcs_pkg::req_type b;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 82) b.mode = lcs_pkg::MODE_TICK;
      else if (pick < 90) b.mode = lcs_pkg::MODE_SWEEP;
      else if (pick < 97) b.mode = lcs_pkg::MODE_CONVERGE;
      else b.mode = MODE_UNUSED;
      b.key_valid = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 35) b.key_code = lcs_pkg::KEY_FASTER;
      else if (pick < 60) b.key_code = lcs_pkg::KEY_SLOWER;
      else if (pick < 63) b.key_code = lcs_pkg::KEY_STOP;
      else b.key_code = 8'($urandom_range(0, 255));
      return b;
   endfunction

   task automatic send_beat(input lcs_pkg::req_type b);
      if (!steady && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode <= b.mode;
      req_bus.key_valid <= b.key_valid;
      req_bus.key_code <= b.key_code;
      do @(posedge clock); while (!req_bus.ready);
      predictor.note_beat(b);
   endtask

   // Stop offering and wait until every owed display has come back
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (predictor.expected_displays.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [lcs_pkg::CSR_IDX_W-1:0] index,
                            input logic [lcs_pkg::CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      predictor.set_register(index, data);
   endtask

   // Block must be idle; also pokes the unused index, which must be ignored
   task automatic program_delays(input logic [lcs_pkg::STEP_W-1:0] step,
                                 input logic [lcs_pkg::LIMIT_W-1:0] floor_val,
                                 input logic [lcs_pkg::LIMIT_W-1:0] ceiling_val);
      write_csr(lcs_pkg::CSR_DELAY_STEP, lcs_pkg::CSR_DATA_W'(step));
      write_csr(lcs_pkg::CSR_DELAY_FLOOR, floor_val);
      write_csr(lcs_pkg::CSR_DELAY_CEILING, ceiling_val);
      write_csr(CSR_UNUSED, lcs_pkg::CSR_DATA_W'($urandom_range(0, 131071)));
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      reset <= 1'b1;
      csr_write_en <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.mode <= lcs_pkg::MODE_TICK;
      req_bus.key_valid <= 1'b0;
      req_bus.key_code <= 8'h00;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset delays: idle ticks, starts, restarts, keys, stop
      send_beat(beat(lcs_pkg::MODE_TICK, 1'b1, lcs_pkg::KEY_FASTER));
      send_beat(beat(MODE_UNUSED, 1'b1, lcs_pkg::KEY_SLOWER));
      send_beat(beat(lcs_pkg::MODE_SWEEP, 1'b0, 8'h00));
      send_beat(beat(lcs_pkg::MODE_TICK, 1'b1, lcs_pkg::KEY_FASTER));
      send_beat(beat(lcs_pkg::MODE_TICK, 1'b1, lcs_pkg::KEY_SLOWER));
      send_beat(beat(lcs_pkg::MODE_TICK, 1'b1, KEY_OTHER));
      send_beat(beat(lcs_pkg::MODE_TICK, 1'b0, lcs_pkg::KEY_STOP));
      send_beat(beat(MODE_UNUSED, 1'b1, lcs_pkg::KEY_STOP));
      send_beat(beat(lcs_pkg::MODE_CONVERGE, 1'b1, 8'h00));
      send_beat(beat(lcs_pkg::MODE_TICK, 1'b1, lcs_pkg::KEY_SLOWER));
      send_beat(beat(lcs_pkg::MODE_SWEEP, 1'b0, KEY_OTHER));
      send_beat(beat(lcs_pkg::MODE_TICK, 1'b1, lcs_pkg::KEY_STOP));
      send_beat(beat(lcs_pkg::MODE_TICK, 1'b1, lcs_pkg::KEY_STOP));
      drain_results();

      // Huge step: lowering past zero, zero dwell, raising into saturation
      program_delays(STEP_MAX, 17'd1, LIMIT_MAX);
      send_beat(beat(lcs_pkg::MODE_CONVERGE, 1'b0, 8'h00));
      send_beat(beat(lcs_pkg::MODE_TICK, 1'b1, lcs_pkg::KEY_FASTER));
      send_beat(beat(lcs_pkg::MODE_CONVERGE, 1'b0, 8'h00));
      send_beat(beat(lcs_pkg::MODE_TICK, 1'b0, 8'h00));
      send_beat(beat(lcs_pkg::MODE_TICK, 1'b1, lcs_pkg::KEY_SLOWER));
      send_beat(beat(lcs_pkg::MODE_TICK, 1'b1, lcs_pkg::KEY_SLOWER));
      send_beat(beat(lcs_pkg::MODE_TICK, 1'b1, lcs_pkg::KEY_SLOWER));
      send_beat(beat(lcs_pkg::MODE_TICK, 1'b1, lcs_pkg::KEY_FASTER));
      drain_results();

      // Ceiling below the dwell pulls it down; floor at maximum blocks lowering
      program_delays(16'd1, LIMIT_MAX, 17'd1);
      send_beat(beat(lcs_pkg::MODE_CONVERGE, 1'b0, 8'h00));
      send_beat(beat(lcs_pkg::MODE_TICK, 1'b1, lcs_pkg::KEY_SLOWER));
      send_beat(beat(lcs_pkg::MODE_TICK, 1'b1, lcs_pkg::KEY_FASTER));
      drain_results();

      // Random phases, each under its own delay setting
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: program_delays(16'd1, 17'd1, 17'd1);
            1: program_delays(STEP_MAX, 17'd1, LIMIT_MAX);
            default: program_delays(lcs_pkg::STEP_W'($urandom_range(1, 5)),
                                    lcs_pkg::LIMIT_W'($urandom_range(1, 4)),
                                    lcs_pkg::LIMIT_W'($urandom_range(1, 30)));
         endcase
         steady = (p == RANDOM_PHASES - 1);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if (p == 2 && n == 100) hold_pending = 1;
            if (p == 3 && n == 100) drain_results();
            send_beat(random_beat());
         end
         drain_results();
      end

      if (predictor.mismatches == 0 && predictor.expected_displays.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
